// ----- design/assert_macros.svh -----
// Assertion macros for the design files; only the top module uses them.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The condition must never hold.
`define SMR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- design/smr_pkg.sv -----
// Shared constants, types and helpers of the spiral order matrix reader.
// No dependencies; smr_if, smr_ctrl, smr_dp and the top refer to it by scoped names.
package smr_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int ROW_W       = 3;
  localparam int COL_W       = 3;
  localparam int DIM_W       = 4;
  localparam int CNT_W       = 7;
  localparam int SP_CNT_W    = 6;
  localparam int VAL_W       = 32;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int DIV_STEPS   = 6;
  localparam int STEP_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(MAX_COLS);

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // input transfer this cycle
    logic div_start;  // restart the load position recalculation
    logic div_step;   // one step of the recalculation
    logic rd_issue;   // read the next spiral element
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_size;
    logic load_last;
    logic div_done;
    logic shown_final;
  } sts_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_COLS + int'(c));
  endfunction

endpackage

// ----- design/smr_if.sv -----
// Valid/ready channel interfaces for element input and spiral output.
// Depends on smr_pkg for the field widths.
interface smr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [smr_pkg::VAL_W-1:0]     element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

interface smr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [smr_pkg::VAL_W-1:0]     out_value;
  logic        [smr_pkg::ROW_W-1:0]     out_row;
  logic        [smr_pkg::COL_W-1:0]     out_col;
  logic                                 is_final;

  modport source (output valid, output out_value, output out_row, output out_col,
                  output is_final, input ready);
  modport sink (input valid, input out_value, input out_row, input out_col,
                input is_final, output ready);
endinterface

// ----- design/spiral_order_matrix_reader.sv -----
// Channel   Dir  Handshake      Payload
// in_if     in   valid/ready    element_value (32b signed, row-major order)
// out_if    out  valid/ready    out_value, out_row, out_col, is_final
// cfg_*     in   write enable   cfg_index selects row_count or col_count
//
// The transfer that completes the matrix is followed by a store read, then
// one spiral element per cycle while out_if.ready is high; the store's
// single read port sets that pace. A configuration write while loading,
// unless it meets the transfer that completes the matrix, recalculates the
// load position, during which no input is taken. Reset clears the control
// state, size registers and load position only; the element store is not cleared.
// Depends on smr_pkg, smr_if, smr_ctrl, smr_dp and assert_macros.svh.
`include "assert_macros.svh"

module spiral_order_matrix_reader (
  input  logic                              clk,
  input  logic                              rst_n,
  smr_in_if.sink                            in_if,
  smr_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [smr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smr_pkg::CFG_W-1:0]         cfg_wdata
);

  smr_pkg::cmd_t cmd;
  smr_pkg::sts_t sts;

  smr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cfg_we    (cfg_we),
    .sts       (sts),
    .cmd       (cmd)
  );

  smr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .element_value (in_if.element_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_value     (out_if.out_value),
    .out_row       (out_if.out_row),
    .out_col       (out_if.out_col),
    .is_final      (out_if.is_final)
  );

  // Loading and readout never overlap.
  `SMR_ASSERT_NEVER(a_load_emit_excl, in_if.ready && out_if.valid, "input and output both open")
  // The final spiral transfer returns the block to loading.
  `SMR_ASSERT_NEXT(a_final_to_idle, out_if.valid && out_if.ready && out_if.is_final, in_if.ready, "no input after final transfer")
  // A configuration write while loading pauses input for the recalculation or the readout.
  `SMR_ASSERT_NEXT(a_cfg_pause, cfg_we && in_if.ready, !in_if.ready, "input open right after config write")
  // A store read is issued only for an element that is then offered.
  `SMR_ASSERT_NEXT(a_read_shown, cmd.rd_issue, out_if.valid, "read issued without output")

endmodule

// ----- design/smr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module smr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/smr_ctrl.sv -----
// Controller state machine: handshakes, load, recalculation and readout sequencing.
// Depends on smr_pkg for the command and status structs.
module smr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          cfg_we,
  input  smr_pkg::sts_t sts,
  output smr_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_READ = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        // A transfer that completes the matrix takes precedence; it leaves the
        // load position at zero, so no recalculation is needed after it.
        if (in_valid && sts.load_last && !sts.zero_size) begin
          state_nxt = ST_READ;
        end else if (cfg_we) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cfg_we) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.shown_final) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.rd_issue = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/smr_dp.sv -----
// Datapath: configuration, load position, spiral walker and element store.
// Depends on smr_pkg and instantiates smr_ram.
module smr_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic        [smr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [smr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic signed [smr_pkg::VAL_W-1:0]     element_value,
  input  smr_pkg::cmd_t                        cmd,
  output smr_pkg::sts_t                        sts,
  output logic signed [smr_pkg::VAL_W-1:0]     out_value,
  output logic        [smr_pkg::ROW_W-1:0]     out_row,
  output logic        [smr_pkg::COL_W-1:0]     out_col,
  output logic                                 is_final
);

  localparam int ROW_W  = smr_pkg::ROW_W;
  localparam int COL_W  = smr_pkg::COL_W;
  localparam int DIM_W  = smr_pkg::DIM_W;
  localparam int CNT_W  = smr_pkg::CNT_W;
  localparam int SPW    = smr_pkg::SP_CNT_W;
  localparam int STEP_W = smr_pkg::STEP_W;
  localparam int ADDR_W = smr_pkg::ADDR_W;

  // Configuration registers.
  logic [DIM_W-1:0] row_count_r, col_count_r;

  // Load position.
  logic [CNT_W-1:0] loaded_count_r;
  logic [ROW_W-1:0] ld_row_r;
  logic [COL_W-1:0] ld_col_r;

  // Recalculation of the load position by restoring division.
  logic [STEP_W-1:0] step_r;
  logic [COL_W-1:0]  rem_r;
  logic [ROW_W-1:0]  quo_r;

  // Spiral walker and the registers of the element on display.
  logic [ROW_W-1:0]  wk_row_r, top_r, bottom_r;
  logic [COL_W-1:0]  wk_col_r, left_r, right_r;
  smr_pkg::dir_t     dir_r;
  logic [SPW-1:0]    sp_cnt_r;
  logic [ROW_W-1:0]  show_row_r;
  logic [COL_W-1:0]  show_col_r;
  logic              show_final_r;

  logic [DIM_W-1:0]   rows_eff, cols_eff;
  logic [2*DIM_W-1:0] prod;
  logic [CNT_W-1:0]   total;
  logic               restart;
  logic [ROW_W-1:0]   base_row;
  logic [COL_W-1:0]   base_col;
  logic [CNT_W-1:0]   base_cnt, cnt_inc;
  logic [DIM_W-1:0]   col_inc;
  logic               col_wrap;
  logic               do_load;

  logic [ADDR_W-1:0]  div_src;
  logic               div_bit;
  logic [DIM_W-1:0]   trial;
  logic               trial_ge;
  logic [COL_W-1:0]   rem_nxt;
  logic [ROW_W-1:0]   quo_nxt;

  logic               sp_last;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [smr_pkg::VAL_W-1:0] rdata;

  always_comb begin
    rows_eff = (row_count_r > DIM_W'(smr_pkg::MAX_ROWS)) ? DIM_W'(smr_pkg::MAX_ROWS)
                                                         : row_count_r;
    cols_eff = (col_count_r > DIM_W'(smr_pkg::MAX_COLS)) ? DIM_W'(smr_pkg::MAX_COLS)
                                                         : col_count_r;
    prod     = (2*DIM_W)'(rows_eff) * (2*DIM_W)'(cols_eff);
    total    = prod[CNT_W-1:0];

    // A load position at or past the element total starts a new matrix.
    restart  = (loaded_count_r >= total);
    base_row = restart ? '0 : ld_row_r;
    base_col = restart ? '0 : ld_col_r;
    base_cnt = restart ? '0 : loaded_count_r;
    cnt_inc  = base_cnt + CNT_W'(1);
    col_inc  = {1'b0, base_col} + DIM_W'(1);
    col_wrap = (col_inc == cols_eff);

    sts.zero_size = (rows_eff == '0) || (cols_eff == '0);
    sts.load_last = (cnt_inc == total);
    do_load       = cmd.load && !sts.zero_size;
    waddr         = smr_pkg::store_addr(base_row, base_col);

    // Quotient bits come out most significant first.
    div_src  = loaded_count_r[ADDR_W-1:0];
    div_bit  = div_src[STEP_W'(smr_pkg::DIV_STEPS - 1) - step_r];
    trial    = {rem_r, div_bit};
    trial_ge = (trial >= cols_eff);
    rem_nxt  = trial_ge ? COL_W'(trial - cols_eff) : trial[COL_W-1:0];
    quo_nxt  = {quo_r[ROW_W-2:0], trial_ge};
    sts.div_done = (step_r == STEP_W'(smr_pkg::DIV_STEPS - 1));

    sp_last          = (sp_cnt_r == SPW'(total - CNT_W'(1)));
    raddr            = smr_pkg::store_addr(wk_row_r, wk_col_r);
    sts.shown_final  = show_final_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= smr_pkg::ROWS_RESET;
      col_count_r    <= smr_pkg::COLS_RESET;
      loaded_count_r <= '0;
      ld_row_r       <= '0;
      ld_col_r       <= '0;
      step_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          smr_pkg::REG_ROW_COUNT: row_count_r <= cfg_wdata;
          smr_pkg::REG_COL_COUNT: col_count_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (do_load) begin
        if (sts.load_last) begin
          loaded_count_r <= '0;
          ld_row_r       <= '0;
          ld_col_r       <= '0;
        end else begin
          loaded_count_r <= cnt_inc;
          if (col_wrap) begin
            ld_row_r <= base_row + ROW_W'(1);
            ld_col_r <= '0;
          end else begin
            ld_row_r <= base_row;
            ld_col_r <= col_inc[COL_W-1:0];
          end
        end
      end
      if (cmd.div_start) begin
        step_r <= '0;
      end else if (cmd.div_step) begin
        step_r <= step_r + STEP_W'(1);
        if (sts.div_done) begin
          ld_row_r <= quo_nxt;
          ld_col_r <= rem_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end

    if (do_load && sts.load_last) begin
      wk_row_r <= '0;
      wk_col_r <= '0;
      top_r    <= '0;
      left_r   <= '0;
      bottom_r <= ROW_W'(rows_eff - DIM_W'(1));
      right_r  <= COL_W'(cols_eff - DIM_W'(1));
      dir_r    <= smr_pkg::DIR_RIGHT;
      sp_cnt_r <= '0;
    end else if (cmd.rd_issue) begin
      show_row_r   <= wk_row_r;
      show_col_r   <= wk_col_r;
      show_final_r <= sp_last;
      sp_cnt_r     <= sp_cnt_r + SPW'(1);
      // Step along the current edge; at its end shrink that edge and turn.
      case (dir_r)
        smr_pkg::DIR_RIGHT: begin
          if (wk_col_r == right_r) begin
            top_r    <= top_r + ROW_W'(1);
            wk_row_r <= wk_row_r + ROW_W'(1);
            dir_r    <= smr_pkg::DIR_DOWN;
          end else begin
            wk_col_r <= wk_col_r + COL_W'(1);
          end
        end
        smr_pkg::DIR_DOWN: begin
          if (wk_row_r == bottom_r) begin
            right_r  <= right_r - COL_W'(1);
            wk_col_r <= wk_col_r - COL_W'(1);
            dir_r    <= smr_pkg::DIR_LEFT;
          end else begin
            wk_row_r <= wk_row_r + ROW_W'(1);
          end
        end
        smr_pkg::DIR_LEFT: begin
          if (wk_col_r == left_r) begin
            bottom_r <= bottom_r - ROW_W'(1);
            wk_row_r <= wk_row_r - ROW_W'(1);
            dir_r    <= smr_pkg::DIR_UP;
          end else begin
            wk_col_r <= wk_col_r - COL_W'(1);
          end
        end
        smr_pkg::DIR_UP: begin
          if (wk_row_r == top_r) begin
            left_r   <= left_r + COL_W'(1);
            wk_col_r <= wk_col_r + COL_W'(1);
            dir_r    <= smr_pkg::DIR_RIGHT;
          end else begin
            wk_row_r <= wk_row_r - ROW_W'(1);
          end
        end
        default: begin
          dir_r <= smr_pkg::DIR_RIGHT;
        end
      endcase
    end
  end

  smr_ram #(
    .WIDTH (smr_pkg::VAL_W),
    .DEPTH (smr_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_load),
    .waddr (waddr),
    .wdata (element_value),
    .re    (cmd.rd_issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_value = rdata;
  assign out_row   = show_row_r;
  assign out_col   = show_col_r;
  assign is_final  = show_final_r;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for spiral_order_matrix_reader: loads matrices one element per
// transfer, predicts the clockwise spiral readout and checks every output transfer.
// Depends on smr_pkg, the channel interfaces in smr_if and the design sources.
`timescale 1ns / 100ps

module tb_top;

  localparam int VAL_W       = smr_pkg::VAL_W;
  localparam int ROW_W       = smr_pkg::ROW_W;
  localparam int COL_W       = smr_pkg::COL_W;
  localparam int CFG_W       = smr_pkg::CFG_W;
  localparam int CFG_IDX_W   = smr_pkg::CFG_IDX_W;
  localparam int STORE_DEPTH = smr_pkg::STORE_DEPTH;
  localparam int MAX_ROWS    = smr_pkg::MAX_ROWS;
  localparam int MAX_COLS    = smr_pkg::MAX_COLS;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = smr_pkg::REG_ROW_COUNT;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = smr_pkg::REG_COL_COUNT;
  localparam logic [CFG_W-1:0]     ROWS_RESET    = smr_pkg::ROWS_RESET;
  localparam logic [CFG_W-1:0]     COLS_RESET    = smr_pkg::COLS_RESET;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_ITEMS   = 360;
  localparam int NUM_ROWS_TBL   = 36;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    fin;
  } spiral_elem_t;

  typedef enum logic {STEP_CFG, STEP_ELEM} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_data;
    logic [VAL_W-1:0]     value;
    logic                 typed;      // expectation is written out in this row
    logic                 typed_out;  // the typed row produces one element
    spiral_elem_t         typed_res;
  } directed_row_t;

  localparam spiral_elem_t NO_RES = '0;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  smr_in_if  in_ch ();
  smr_out_if out_ch ();

  spiral_order_matrix_reader dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Matrix shadow of the block: store, load position and size registers.
  logic [VAL_W-1:0] store_model [STORE_DEPTH];
  int               loaded_n;
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;

  spiral_elem_t spiral_q [$];
  int           err_count = 0;
  bit           calm = 1'b0;
  bit           hold_req = 1'b0;

  // Size registers, 1x1 extremes, zero sizes, a shrink that restarts the load,
  // an oversized row count and a small square.
  directed_row_t directed_tbl [NUM_ROWS_TBL] = '{
    '{STEP_CFG,  REG_ROW_COUNT, 4'd1,  32'h0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG,  REG_COL_COUNT, 4'd1,  32'h0, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h8000_0000, 1'b1, 1'b1,
      '{32'h8000_0000, 3'd0, 3'd0, 1'b1}},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h7FFF_FFFF, 1'b1, 1'b1,
      '{32'h7FFF_FFFF, 3'd0, 3'd0, 1'b1}},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0000, 1'b1, 1'b1,
      '{32'h0000_0000, 3'd0, 3'd0, 1'b1}},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'hFFFF_FFFF, 1'b1, 1'b1,
      '{32'hFFFF_FFFF, 3'd0, 3'd0, 1'b1}},
    '{STEP_CFG,  REG_ROW_COUNT, 4'd0,  32'h0, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h5A5A_5A5A, 1'b1, 1'b0, NO_RES},
    '{STEP_CFG,  REG_ROW_COUNT, 4'd1,  32'h0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG,  REG_COL_COUNT, 4'd0,  32'h0, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'hA5A5_A5A5, 1'b1, 1'b0, NO_RES},
    '{STEP_CFG,  REG_COL_COUNT, 4'd2,  32'h0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG,  REG_ROW_COUNT, 4'd3,  32'h0, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0011, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0022, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0033, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0044, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG,  REG_ROW_COUNT, 4'd1,  32'h0, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h1357_9BDF, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h8642_0ECA, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG,  REG_ROW_COUNT, 4'd12, 32'h0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG,  REG_COL_COUNT, 4'd1,  32'h0, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0100, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0200, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0300, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0400, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0500, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0600, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0700, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_0800, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG,  REG_ROW_COUNT, 4'd2,  32'h0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG,  REG_COL_COUNT, 4'd2,  32'h0, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'hC0DE_0001, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h0000_FFFF, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'hFFFF_0000, 1'b0, 1'b0, NO_RES},
    '{STEP_ELEM, REG_ROW_COUNT, 4'd0,  32'h3C3C_C3C3, 1'b0, 1'b0, NO_RES}
  };

  function automatic int clamp_dim(input logic [CFG_W-1:0] d, input int max_d);
    return (int'(d) > max_d) ? max_d : int'(d);
  endfunction

  function automatic void push_spiral_elem(input int r, input int c, input bit last,
                                           input bit keep);
    spiral_elem_t e;
    e.value = store_model[(r * MAX_COLS + c) % STORE_DEPTH];
    e.row   = ROW_W'(r);
    e.col   = COL_W'(c);
    e.fin   = last;
    if (keep) spiral_q.push_back(e);
  endfunction

  // Stores one element and, when it completes the matrix, queues the whole spiral.
  function automatic void load_and_predict(input logic [VAL_W-1:0] v, input bit keep);
    int rows, cols, total, top, bot, lft, rgt, i, cnt;
    rows  = clamp_dim(rows_reg, MAX_ROWS);
    cols  = clamp_dim(cols_reg, MAX_COLS);
    total = rows * cols;
    if (total == 0) return;
    if (loaded_n >= total) loaded_n = 0;
    store_model[((loaded_n / cols) * MAX_COLS + loaded_n % cols) % STORE_DEPTH] = v;
    loaded_n++;
    if (loaded_n < total) return;
    loaded_n = 0;
    cnt = 0;
    top = 0;
    bot = rows - 1;
    lft = 0;
    rgt = cols - 1;
    while (cnt < total) begin
      for (i = lft; i <= rgt && cnt < total; i++) begin
        push_spiral_elem(top, i, cnt == total - 1, keep);
        cnt++;
      end
      top++;
      for (i = top; i <= bot && cnt < total; i++) begin
        push_spiral_elem(i, rgt, cnt == total - 1, keep);
        cnt++;
      end
      rgt--;
      for (i = rgt; i >= lft && cnt < total; i--) begin
        push_spiral_elem(bot, i, cnt == total - 1, keep);
        cnt++;
      end
      bot--;
      for (i = bot; i >= top && cnt < total; i--) begin
        push_spiral_elem(i, lft, cnt == total - 1, keep);
        cnt++;
      end
      lft++;
    end
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'($urandom_range(MAX_ROWS + 1, 15));
      2, 3: return CFG_W'($urandom_range(5, 8));
      default: return CFG_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Leaves valid high after the transfer so back-to-back items need no extra edge.
  task automatic offer_element(input logic [VAL_W-1:0] v, input bit typed,
                               input bit typed_out, input spiral_elem_t typed_res);
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.element_value <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    load_and_predict(v, !typed);
    if (typed && typed_out) spiral_q.push_back(typed_res);
  endtask

  task automatic offer_random();
    offer_element(pick_value(), 1'b0, 1'b0, NO_RES);
  endtask

  // Always waits for a clock edge before it returns, so valid is never driven twice in one step.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (spiral_q.size() != 0);
  endtask

  // Size registers change only with the block idle and its recalculation finished.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROW_COUNT) rows_reg = data;
    else cols_reg = data;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: checks each transfer, holds off on request, otherwise stalls at random unless calm is set.
  initial begin
    int           hold_left;
    spiral_elem_t got;
    spiral_elem_t want;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.out_value, out_ch.out_row, out_ch.out_col, out_ch.is_final};
        if (spiral_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected element: expected none, actual value %h row %0d col %0d final %0b",
                   $time, got.value, got.row, got.col, got.fin);
        end else begin
          want = spiral_q.pop_front();
          if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
              got.fin !== want.fin) begin
            err_count++;
            $display("%0t: element mismatch: expected value %h row %0d col %0d final %0b",
                     $time, want.value, want.row, want.col, want.fin);
            $display("%0t:                   actual   value %h row %0d col %0d final %0b",
                     $time, got.value, got.row, got.col, got.fin);
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // Ends the run when neither channel completes a transfer for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[spiral_order_matrix_reader] ERROR");
    $finish;
  end

  initial begin
    int               row_i;
    int               k;
    int               random_items;
    int               eff_total;
    int               n_items;
    logic [CFG_W-1:0] rows_pick;
    logic [CFG_W-1:0] cols_pick;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_ROW_COUNT;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.element_value <= '0;
    rows_reg = ROWS_RESET;
    cols_reg = COLS_RESET;
    loaded_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row_i = 0; row_i < NUM_ROWS_TBL; row_i++) begin
      if (directed_tbl[row_i].kind == STEP_CFG) begin
        write_reg(directed_tbl[row_i].reg_idx, directed_tbl[row_i].reg_data);
      end else begin
        offer_element(directed_tbl[row_i].value, directed_tbl[row_i].typed,
                      directed_tbl[row_i].typed_out, directed_tbl[row_i].typed_res);
      end
    end

    // Two full 8x8 matrices write every store entry, so later resizes in the middle
    // of a load never read an entry that was not written. The receiver holds off
    // meanwhile, so the block fills up and stalls its input.
    write_reg(REG_ROW_COUNT, ROWS_RESET);
    write_reg(REG_COL_COUNT, COLS_RESET);
    hold_req = 1'b1;
    repeat (2 * MAX_ROWS * MAX_COLS) offer_random();
    random_items = 2 * MAX_ROWS * MAX_COLS;

    // A stretch with no idling on either side, with one full pause of the sender.
    write_reg(REG_ROW_COUNT, 4'd4);
    write_reg(REG_COL_COUNT, 4'd5);
    calm = 1'b1;
    for (k = 0; k < 60; k++) begin
      offer_random();
      if (k == 19) drain_results();
    end
    calm = 1'b0;
    random_items += 60;

    while (random_items < RANDOM_ITEMS) begin
      rows_pick = pick_dim();
      cols_pick = pick_dim();
      write_reg(REG_ROW_COUNT, rows_pick);
      write_reg(REG_COL_COUNT, cols_pick);
      eff_total = clamp_dim(rows_pick, MAX_ROWS) * clamp_dim(cols_pick, MAX_COLS);
      if (eff_total == 0) begin
        repeat ($urandom_range(1, 3)) offer_random();
      end else begin
        n_items = eff_total * ((eff_total > 20) ? 1 : $urandom_range(1, 3));
        // Sometimes stop in the middle of a matrix so the next size change hits a load.
        if (eff_total > 1 && $urandom_range(0, 99) < 30)
          n_items += $urandom_range(1, eff_total - 1);
        for (k = 0; k < n_items; k++) begin
          offer_random();
          if (k % eff_total == eff_total - 1 && $urandom_range(0, 99) < 20) drain_results();
        end
        random_items += n_items;
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("[spiral_order_matrix_reader] OK");
    end else begin
      $display("[spiral_order_matrix_reader] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/smr_pkg.sv
design/smr_if.sv
design/smr_ram.sv
design/smr_ctrl.sv
design/smr_dp.sv
design/spiral_order_matrix_reader.sv
dv/tb_top.sv
